FILE: src/rau_pkg.sv
// shared types and constants for the rational arithmetic unit
`timescale 1ns / 1ps
package rau_pkg;

	// width of the exact intermediate products and of the gcd / divide datapath
	localparam int WIDE = 64;
	localparam int CNT_W = $clog2(WIDE);

	typedef logic [WIDE-1:0] wide_t;

	// operation codes
	localparam logic [3:0] FN_ADD = 4'd0;
	localparam logic [3:0] FN_SUB = 4'd1;
	localparam logic [3:0] FN_MUL = 4'd2;
	localparam logic [3:0] FN_DIV = 4'd3;
	localparam logic [3:0] FN_EQ  = 4'd4;
	localparam logic [3:0] FN_NE  = 4'd5;
	localparam logic [3:0] FN_LT  = 4'd6;
	localparam logic [3:0] FN_GT  = 4'd7;
	localparam logic [3:0] FN_LE  = 4'd8;
	localparam logic [3:0] FN_GE  = 4'd9;

	// start / done pair between the sequencer and an iterative unit
	typedef struct packed {
		logic go;
	} unit_ctl_t;

	typedef struct packed {
		logic done;
	} unit_sts_t;

endpackage

FILE: src/rational_arithmetic_unit.sv
// rational arithmetic unit top level: sequencer, shared multiplier, gcd and divide units
// unused codes and zero denominators finish straight from idle; comparisons form the
//   cross products and evaluate; arithmetic forms its products, takes the signs, runs
//   the binary gcd over 64 bits and divides both parts by it in the restoring divider
// throughput: one request at a time, busy stays high until the result strobe
// the result is shown for one cycle with done, the receiver cannot stall it
// arst_n clears the sequencer and strobes, payload registers are not reset
`timescale 1ns / 1ps
module rational_arithmetic_unit
	import rau_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [3:0]  func,
	input  logic [31:0] a_num,
	input  logic [30:0] a_den,
	input  logic [31:0] b_num,
	input  logic [30:0] b_den,
	output logic        busy,
	output logic        done,
	output logic [31:0] res_num,
	output logic [30:0] res_den,
	output logic        cmp_true,
	output logic        overflow,
	output logic        zero_divide
);

	// limit on reduced magnitudes: numerator up to LIM when negative, else LIM - 1
	localparam wide_t LIM = wide_t'(1) << (VALUE_WIDTH - 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_M0,
		S_M1,
		S_M2,
		S_EVAL,
		S_SIGN,
		S_GCD,
		S_DIVN,
		S_DIVD,
		S_FIN
	} state_t;

	state_t state_q;

	// operands, sign-extended numerators and zero-extended denominators
	logic signed [32:0] an_q, ad_q, bn_q, bd_q;
	logic [3:0]         func_q;

	// narrowed views of the request fields at the configured width
	logic signed [VALUE_WIDTH-1:0] an_v, bn_v;
	logic [VALUE_WIDTH-2:0]        ad_v, bd_v;

	// cross products and the unreduced fraction
	logic signed [WIDE-1:0] p1_q, p2_q, p3_q;
	logic signed [WIDE-1:0] s_q, t_q;
	wide_t                  sm_q, tm_q;
	logic                   neg_q;

	// shared multiplier
	logic signed [32:0] mul_x, mul_y;
	logic signed [65:0] prod;
	logic signed [WIDE-1:0] prod_w;

	// iterative units
	unit_ctl_t gcd_ctl, div_ctl;
	unit_sts_t gcd_sts, div_sts;
	logic      gcd_go_q, div_go_q;
	wide_t     g;
	wide_t     quo;
	wide_t     div_num;

	// result registers
	logic        done_q;
	logic [31:0] res_num_q;
	logic [30:0] res_den_q;
	logic        cmp_q, ovf_q, zdv_q;

	logic        cmp_hold;
	logic        is_neg;
	wide_t       fin_lim;

	assign an_v = a_num[VALUE_WIDTH-1:0];
	assign bn_v = b_num[VALUE_WIDTH-1:0];
	assign ad_v = a_den[VALUE_WIDTH-2:0];
	assign bd_v = b_den[VALUE_WIDTH-2:0];

	// operand select: mul needs an*bn and ad*bd, div an*bd and ad*bn,
	// add and sub an*bd, ad*bn and ad*bd, comparisons an*bd and ad*bn
	always_comb begin
		mul_x = ad_q;
		mul_y = bd_q;
		case (state_q)
			S_M0: begin
				mul_x = an_q;
				mul_y = (func_q == FN_MUL) ? bn_q : bd_q;
			end
			S_M1: begin
				mul_x = ad_q;
				mul_y = (func_q == FN_MUL) ? bd_q : bn_q;
			end
			default: begin
				mul_x = ad_q;
				mul_y = bd_q;
			end
		endcase
	end

	assign prod   = mul_x * mul_y;
	assign prod_w = prod[WIDE-1:0];

	// relation of the two cross products for the comparison codes
	always_comb begin
		case (func_q)
			FN_EQ:   cmp_hold = (p1_q == p2_q);
			FN_NE:   cmp_hold = (p1_q != p2_q);
			FN_LT:   cmp_hold = (p1_q <  p2_q);
			FN_GT:   cmp_hold = (p1_q >  p2_q);
			FN_LE:   cmp_hold = (p1_q <= p2_q);
			default: cmp_hold = (p1_q >= p2_q);
		endcase
	end

	// a zero reduced numerator carries no sign
	assign is_neg  = neg_q && (sm_q != '0);
	assign fin_lim = is_neg ? LIM : LIM - 1'b1;

	assign div_num = (state_q == S_DIVN) ? sm_q : tm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			gcd_go_q <= 1'b0;
			div_go_q <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			gcd_go_q <= 1'b0;
			div_go_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						an_q      <= 33'(an_v);
						bn_q      <= 33'(bn_v);
						ad_q      <= $signed({1'b0, 32'(ad_v)});
						bd_q      <= $signed({1'b0, 32'(bd_v)});
						func_q    <= func;
						res_num_q <= '0;
						res_den_q <= '0;
						cmp_q     <= 1'b0;
						ovf_q     <= 1'b0;
						zdv_q     <= 1'b0;
						if (func > FN_GE) begin
							// unused code: all-zero result
							done_q <= 1'b1;
						end else if (ad_v == '0 || bd_v == '0) begin
							zdv_q  <= 1'b1;
							done_q <= 1'b1;
						end else begin
							state_q <= S_M0;
						end
					end
				end
				S_M0: begin
					p1_q    <= prod_w;
					state_q <= S_M1;
				end
				S_M1: begin
					p2_q    <= prod_w;
					// add and sub need the third product for the denominator
					state_q <= (func_q == FN_ADD || func_q == FN_SUB) ? S_M2 : S_EVAL;
				end
				S_M2: begin
					p3_q    <= prod_w;
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					case (func_q)
						FN_ADD: begin
							s_q     <= p1_q + p2_q;
							t_q     <= p3_q;
							state_q <= S_SIGN;
						end
						FN_SUB: begin
							s_q     <= p1_q - p2_q;
							t_q     <= p3_q;
							state_q <= S_SIGN;
						end
						FN_MUL, FN_DIV: begin
							s_q     <= p1_q;
							t_q     <= p2_q;
							state_q <= S_SIGN;
						end
						default: begin
							// comparisons finish here
							cmp_q   <= cmp_hold;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_SIGN: begin
					if (t_q == '0) begin
						// division by a zero-valued fraction
						zdv_q   <= 1'b1;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						neg_q    <= s_q[WIDE-1] ^ t_q[WIDE-1];
						sm_q     <= s_q[WIDE-1] ? wide_t'(-s_q) : wide_t'(s_q);
						tm_q     <= t_q[WIDE-1] ? wide_t'(-t_q) : wide_t'(t_q);
						gcd_go_q <= 1'b1;
						state_q  <= S_GCD;
					end
				end
				S_GCD: begin
					if (gcd_sts.done) begin
						div_go_q <= 1'b1;
						state_q  <= S_DIVN;
					end
				end
				S_DIVN: begin
					if (div_sts.done) begin
						sm_q     <= quo;
						div_go_q <= 1'b1;
						state_q  <= S_DIVD;
					end
				end
				S_DIVD: begin
					if (div_sts.done) begin
						tm_q    <= quo;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					// range check of the reduced fraction
					if (tm_q > LIM - 1'b1 || sm_q > fin_lim) begin
						ovf_q <= 1'b1;
					end else begin
						res_num_q <= is_neg ? 32'(-sm_q) : sm_q[31:0];
						res_den_q <= tm_q[30:0];
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign gcd_ctl.go = gcd_go_q;
	assign div_ctl.go = div_go_q;

	rau_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (gcd_ctl),
		.x      (sm_q),
		.y      (tm_q),
		.sts    (gcd_sts),
		.g      (g)
	);

	rau_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.num    (div_num),
		.den    (g),
		.sts    (div_sts),
		.quo    (quo)
	);

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign res_num     = res_num_q;
	assign res_den     = res_den_q;
	assign cmp_true    = cmp_q;
	assign overflow    = ovf_q;
	assign zero_divide = zdv_q;

endmodule

FILE: src/rau_gcd.sv
// binary gcd unit, one compare / subtract / shift step per cycle
`timescale 1ns / 1ps
module rau_gcd
	import rau_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  unit_ctl_t ctl,
	input  wide_t     x,
	input  wide_t     y,
	output unit_sts_t sts,
	output wide_t     g
);

	wide_t            x_q;
	wide_t            y_q;
	logic [CNT_W-1:0] k_q;
	logic             run_q;
	logic             done_q;
	wide_t            g_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.go) begin
				x_q   <= x;
				y_q   <= y;
				k_q   <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				if (x_q == '0) begin
					g_q    <= y_q << k_q;
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else if (y_q == '0) begin
					g_q    <= x_q << k_q;
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else if (!x_q[0] && !y_q[0]) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (x_q >= y_q) begin
					x_q <= x_q - y_q;
				end else begin
					y_q <= y_q - x_q;
				end
			end
		end
	end

	assign sts.done = done_q;
	assign g        = g_q;

endmodule

FILE: src/rau_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module rau_div
	import rau_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  unit_ctl_t ctl,
	input  wide_t     num,
	input  wide_t     den,
	output unit_sts_t sts,
	output wide_t     quo
);

	wide_t            rem_q;
	wide_t            quo_q;
	wide_t            den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [WIDE:0]    shifted;
	logic [WIDE:0]    diff;

	assign shifted = {rem_q, quo_q[WIDE-1]};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.go) begin
				rem_q <= '0;
				quo_q <= num;
				den_q <= den;
				cnt_q <= '1;
				run_q <= 1'b1;
			end else if (run_q) begin
				if (!diff[WIDE]) begin
					rem_q <= diff[WIDE-1:0];
					quo_q <= {quo_q[WIDE-2:0], 1'b1};
				end else begin
					rem_q <= shifted[WIDE-1:0];
					quo_q <= {quo_q[WIDE-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign sts.done = done_q;
	assign quo      = quo_q;

endmodule

FILE: tb/rational_arithmetic_unit_tb.sv
// testbench for the rational arithmetic unit: directed and random requests, scoreboard check
`timescale 1ns / 1ps
module rational_arithmetic_unit_tb
	import rau_pkg::*;
;

	// one result as the block reports it
	typedef struct {
		logic [31:0] num;
		logic [30:0] den;
		logic        cmp;
		logic        ovf;
		logic        zdv;
	} fraction_result_t;

	// predicts the reduced fraction or comparison flag and matches results in order
	class fraction_scoreboard;
		fraction_result_t pending[$];
		int errors = 0;

		function void note_request(logic [3:0] f, logic [31:0] an_r, logic [30:0] ad_r,
				logic [31:0] bn_r, logic [30:0] bd_r);
			longint an, ad, bn, bd, s, t, lhs, rhs;
			longint unsigned sm, tm, x, y, rem, lim;
			bit neg;
			fraction_result_t e;
			e = '{num: '0, den: '0, cmp: 1'b0, ovf: 1'b0, zdv: 1'b0};
			an = longint'($signed(an_r));
			bn = longint'($signed(bn_r));
			ad = longint'(ad_r);
			bd = longint'(bd_r);
			s = 0;
			t = 0;
			if (f > FN_GE) begin
				// unused codes give an all-zero result
			end else if (ad == 0 || bd == 0) begin
				e.zdv = 1'b1;
			end else if (f >= FN_EQ) begin
				// comparisons work on the exact cross products
				lhs = an * bd;
				rhs = ad * bn;
				case (f)
					FN_EQ: e.cmp = (lhs == rhs);
					FN_NE: e.cmp = (lhs != rhs);
					FN_LT: e.cmp = (lhs < rhs);
					FN_GT: e.cmp = (lhs > rhs);
					FN_LE: e.cmp = (lhs <= rhs);
					default: e.cmp = (lhs >= rhs);
				endcase
			end else begin
				case (f)
					FN_ADD: begin s = an * bd + ad * bn; t = ad * bd; end
					FN_SUB: begin s = an * bd - ad * bn; t = ad * bd; end
					FN_MUL: begin s = an * bn; t = ad * bd; end
					default: begin s = an * bd; t = ad * bn; end
				endcase
				if (t == 0) begin
					e.zdv = 1'b1;
				end else begin
					neg = (s < 0) != (t < 0);
					sm = (s < 0) ? -s : s;
					tm = (t < 0) ? -t : t;
					x = sm;
					y = tm;
					while (y != 0) begin
						rem = x % y;
						x = y;
						y = rem;
					end
					sm = sm / x;
					tm = tm / x;
					if (sm == 0)
						neg = 1'b0;
					lim = 64'd1 << 31;
					if (tm > lim - 1 || sm > (neg ? lim : lim - 1)) begin
						e.ovf = 1'b1;
					end else begin
						e.num = 32'(neg ? -sm : sm);
						e.den = 31'(tm);
					end
				end
			end
			pending.push_back(e);
		endfunction

		function void check_result(fraction_result_t got);
			fraction_result_t e;
			if (pending.size() == 0) begin
				$error("result with no request outstanding: num %h den %h", got.num, got.den);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.num !== e.num) begin
				$error("res_num expected %h actual %h", e.num, got.num);
				errors++;
			end
			if (got.den !== e.den) begin
				$error("res_den expected %h actual %h", e.den, got.den);
				errors++;
			end
			if (got.cmp !== e.cmp) begin
				$error("cmp_true expected %b actual %b", e.cmp, got.cmp);
				errors++;
			end
			if (got.ovf !== e.ovf) begin
				$error("overflow expected %b actual %b", e.ovf, got.ovf);
				errors++;
			end
			if (got.zdv !== e.zdv) begin
				$error("zero_divide expected %b actual %b", e.zdv, got.zdv);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic [3:0]  func;
	logic [31:0] a_num;
	logic [30:0] a_den;
	logic [31:0] b_num;
	logic [30:0] b_den;
	logic        busy;
	logic        done;
	logic [31:0] res_num;
	logic [30:0] res_den;
	logic        cmp_true;
	logic        overflow;
	logic        zero_divide;

	fraction_scoreboard sb;
	int idle_pct;

	rational_arithmetic_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.func(func),
		.a_num(a_num),
		.a_den(a_den),
		.b_num(b_num),
		.b_den(b_den),
		.busy(busy),
		.done(done),
		.res_num(res_num),
		.res_den(res_den),
		.cmp_true(cmp_true),
		.overflow(overflow),
		.zero_divide(zero_divide)
	);

	// 20 ns clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// results are shown for one cycle only, so every strobe is checked at the edge it ends on
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result('{num: res_num, den: res_den, cmp: cmp_true,
				ovf: overflow, zdv: zero_divide});
	end

	// hard stop in case the block hangs, far beyond the slowest correct run
	initial begin
		#100ms;
		$display("FAIL rational_arithmetic_unit");
		$finish;
	end

	// one request: random idle gap first, then hold start until the block takes it
	// busy only moves on a rising edge, so its value at the falling edge decides acceptance
	task automatic send_request(logic [3:0] f, logic [31:0] an, logic [30:0] ad,
			logic [31:0] bn, logic [30:0] bd);
		logic taken;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		func = f;
		a_num = an;
		a_den = ad;
		b_num = bn;
		b_den = bd;
		taken = 1'b0;
		while (!taken) begin
			taken = !busy;
			@(posedge clk);
			if (taken)
				sb.note_request(f, an, ad, bn, bd);
			else
				@(negedge clk);
		end
	endtask

	// random request, mostly small values so reduction and equality cases show up often
	task automatic send_random();
		logic [3:0]  f;
		logic [31:0] an, bn;
		logic [30:0] ad, bd;
		int mode;
		int k;
		f = ($urandom_range(99) < 6) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9, 0));
		mode = $urandom_range(99);
		if (mode < 55) begin
			an = $urandom_range(100) - 50;
			bn = $urandom_range(100) - 50;
			ad = 31'($urandom_range(60, 1));
			bd = 31'($urandom_range(60, 1));
		end else if (mode < 70) begin
			// same value written two ways, for eq/ne and zero differences
			an = $urandom_range(2000) - 1000;
			ad = 31'($urandom_range(1000, 1));
			k = $urandom_range(7, 1);
			bn = 32'(an * k);
			bd = 31'(ad * k);
		end else if (mode < 82) begin
			an = 32'($signed(16'($urandom)));
			bn = 32'($signed(16'($urandom)));
			ad = 31'(16'($urandom));
			bd = 31'(16'($urandom));
		end else begin
			an = $urandom;
			bn = $urandom;
			ad = 31'($urandom);
			bd = 31'($urandom);
		end
		// zero denominators now and then, zero numerators for division by zero
		if ($urandom_range(99) < 3)
			ad = '0;
		if ($urandom_range(99) < 3)
			bd = '0;
		if ($urandom_range(99) < 4)
			bn = '0;
		if (ad == 0 && $urandom_range(3) != 0)
			ad = 31'd1;
		if (bd == 0 && $urandom_range(3) != 0)
			bd = 31'd1;
		send_request(f, an, ad, bn, bd);
	endtask

	initial begin
		int waited;
		sb = new();
		idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		func = FN_ADD;
		a_num = '0;
		a_den = 31'd1;
		b_num = '0;
		b_den = 31'd1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part: each operation, extremes, special cases
		send_request(FN_ADD, 32'd1, 31'd2, 32'd1, 31'd3);
		send_request(FN_SUB, 32'd1, 31'd2, 32'd1, 31'd2);              // zero result as 0/1
		send_request(FN_MUL, -32'sd3, 31'd4, 32'd8, 31'd9);
		send_request(FN_DIV, 32'd2, 31'd3, -32'sd4, 31'd5);            // sign moves to numerator
		send_request(FN_DIV, 32'd5, 31'd7, 32'd0, 31'd9);              // divide by zero
		send_request(FN_EQ, 32'd1, 31'd2, 32'd2, 31'd4);               // unreduced but equal
		send_request(FN_NE, 32'd1, 31'd2, 32'd2, 31'd4);
		send_request(FN_LT, -32'sd1, 31'd3, 32'd1, 31'd3);
		send_request(FN_GT, -32'sd1, 31'd3, 32'd1, 31'd3);
		send_request(FN_LE, 32'd7, 31'd9, 32'd14, 31'd18);
		send_request(FN_GE, 32'd7, 31'd9, 32'd15, 31'd18);
		send_request(4'd10, 32'd1, 31'd1, 32'd1, 31'd1);               // unused code
		send_request(4'd15, 32'hffff_ffff, 31'h7fff_ffff, 32'hffff_ffff, 31'h7fff_ffff);
		send_request(FN_ADD, 32'd1, 31'd0, 32'd1, 31'd1);              // zero left denominator
		send_request(FN_LT, 32'd1, 31'd1, 32'd1, 31'd0);               // zero right denominator
		send_request(FN_ADD, 32'h7fff_ffff, 31'd1, 32'h7fff_ffff, 31'd1); // overflow
		send_request(FN_SUB, 32'h8000_0000, 31'd1, 32'd0, 31'd1);      // most negative fits
		send_request(FN_MUL, 32'h8000_0000, 31'd1, 32'hffff_ffff, 31'd1); // 2^31 overflows
		send_request(FN_DIV, 32'h8000_0000, 31'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
		send_request(FN_MUL, 32'h7fff_ffff, 31'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
		send_request(FN_ADD, 32'd1, 31'h7fff_ffff, 32'd1, 31'h7fff_fffe); // denominator overflow
		send_request(FN_GE, 32'h8000_0000, 31'd1, 32'h7fff_ffff, 31'd1);
		send_request(FN_EQ, 32'd0, 31'd5, 32'd0, 31'h7fff_ffff);

		// random part in phases of sender idling: none, heavy, none, light
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 84 : (ph == 3) ? 33 : 0;
			repeat (500) send_random();
		end
		@(negedge clk);
		start = 1'b0;

		// drain, then give the block a longest latency to show any stray strobe
		waited = 0;
		while (sb.pending.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (400) @(posedge clk);
		if (sb.pending.size() != 0) begin
			$error("%0d results never arrived", sb.pending.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("PASS rational_arithmetic_unit");
		else
			$display("FAIL rational_arithmetic_unit");
		$finish;
	end

endmodule
